>>> rtl/lcls_pkg.sv
`timescale 1ns / 1ps
package lcls_pkg;

  localparam int unsigned ReadingBits = 24;
  localparam int unsigned FracBits    = 16;

  typedef struct packed {
    logic                         command;
    logic signed [ReadingBits-1:0] raw_reading;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] mass;
    logic signed [31:0] cal_factor;
    logic [1:0]         status;
  } out_item_t;

  typedef enum logic [1:0] {
    StatusOk       = 2'd0,
    StatusCoincide = 2'd1,
    StatusZero     = 2'd2,
    StatusSat      = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    RegP0Read = 3'd0,
    RegP1Read = 3'd1,
    RegP2Read = 3'd2,
    RegP0Fact = 3'd3,
    RegP1Fact = 3'd4,
    RegP2Fact = 3'd5
  } reg_idx_e;

  localparam int unsigned AddrBits = 5;

endpackage

>>> rtl/lcls_div.sv
`timescale 1ns / 1ps
// Restoring divider, one quotient bit per cycle, unsigned operands.
module lcls_div #(
  parameter int unsigned W = 128
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         start_i,
  input  logic [W-1:0] num_i,
  input  logic [W-1:0] den_i,
  output logic         done_o,
  output logic [W-1:0] quo_o
);

  localparam int unsigned CntBits = $clog2(W + 1);

  logic [W-1:0]       num_q, num_d, quo_q, quo_d, den_q, den_d;
  logic [W:0]         rem_q, rem_d;
  logic [CntBits-1:0] cnt_q, cnt_d;
  logic               busy_q, busy_d, done_q, done_d;
  logic [W:0]         shifted;
  logic [W:0]         diff;

  assign shifted = {rem_q[W-1:0], num_q[W-1]};
  assign diff    = shifted - {1'b0, den_q};

  always_comb begin
    num_d  = num_q;
    quo_d  = quo_q;
    den_d  = den_q;
    rem_d  = rem_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      num_d  = num_i;
      den_d  = den_i;
      rem_d  = '0;
      quo_d  = '0;
      cnt_d  = CntBits'(W);
      busy_d = 1'b1;
    end else if (busy_q) begin
      num_d = {num_q[W-2:0], 1'b0};
      if (!diff[W]) begin
        rem_d = diff;
        quo_d = {quo_q[W-2:0], 1'b1};
      end else begin
        rem_d = shifted;
        quo_d = {quo_q[W-2:0], 1'b0};
      end
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CntBits'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q <= num_d;
    den_q <= den_d;
    rem_q <= rem_d;
    quo_q <= quo_d;
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;

endmodule

>>> rtl/load_cell_lagrange_scale_top.sv
`timescale 1ns / 1ps
// Sequence: a measure item runs three Lagrange terms, each through StMulA, StMulB and
// StMulC, a pass on the shared 128-bit restoring divider and an accumulate, plus a
// divider pass for the mass; a zero factor skips it; tare and coincide go to StOut.
// Flow: one item in flight; the input is ready only in StIdle. The input
// reopens once the result sits in the output register; it stalls only in StOut.
// Reset: async active low; points, factors and zero offset clear to 0.
module load_cell_lagrange_scale_top #(
  parameter int unsigned FRAC_BITS    = lcls_pkg::FracBits
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  // item channels
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  lcls_pkg::in_item_t      in_item_i,
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output lcls_pkg::out_item_t     out_item_o,
  // APB config
  input  logic                    psel,
  input  logic                    penable,
  input  logic                    pwrite,
  input  logic [lcls_pkg::AddrBits-1:0] paddr,
  input  logic [31:0]             pwdata,
  output logic [31:0]             prdata,
  output logic                    pready
);

  localparam int unsigned DW = 128;
  localparam int unsigned RB = lcls_pkg::ReadingBits;

  // ---------------- configuration registers ----------------
  logic signed [RB-1:0] pr_q [3];
  logic signed [31:0]   pf_q [3];
  logic [2:0]           reg_idx;
  logic                 wr_en;

  assign pready  = 1'b1;
  assign reg_idx = paddr[lcls_pkg::AddrBits-1:2];
  assign wr_en   = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < 3; k++) begin
        pr_q[k] <= '0;
        pf_q[k] <= '0;
      end
    end else if (wr_en) begin
      case (reg_idx)
        lcls_pkg::RegP0Read: pr_q[0] <= pwdata[RB-1:0];
        lcls_pkg::RegP1Read: pr_q[1] <= pwdata[RB-1:0];
        lcls_pkg::RegP2Read: pr_q[2] <= pwdata[RB-1:0];
        lcls_pkg::RegP0Fact: pf_q[0] <= pwdata;
        lcls_pkg::RegP1Fact: pf_q[1] <= pwdata;
        lcls_pkg::RegP2Fact: pf_q[2] <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      lcls_pkg::RegP0Read: prdata = 32'(pr_q[0]);
      lcls_pkg::RegP1Read: prdata = 32'(pr_q[1]);
      lcls_pkg::RegP2Read: prdata = 32'(pr_q[2]);
      lcls_pkg::RegP0Fact: prdata = pf_q[0];
      lcls_pkg::RegP1Fact: prdata = pf_q[1];
      lcls_pkg::RegP2Fact: prdata = pf_q[2];
      default:             prdata = '0;
    endcase
  end

  // ---------------- sequencer ----------------
  typedef enum logic [6:0] {
    StIdle = 7'b0000001,
    StMulA = 7'b0000010,  // |a|, |b|, |c|, |d| and the term sign
    StMulB = 7'b0000100,  // a*b, c*d
    StMulC = 7'b0001000,
    StDiv  = 7'b0010000,  // wait on divider
    StMass = 7'b0100000,
    StOut  = 7'b1000000
  } state_e;

  state_e state_q, state_d;

  logic signed [RB-1:0] x_q, zoff_q;
  logic [1:0]           term_q;       // term index, 3 = mass division
  logic [RB:0]          ma_q, mb_q, mc_q, md_q;  // magnitudes
  logic                 neg_q;
  logic [2*RB+1:0]      pab_q, pcd_q;
  logic signed [DW-1:0] sum_q;
  lcls_pkg::out_item_t  res_q;
  logic                 ovalid_q;
  logic                 fast_q;       // tare or coincide: no arithmetic
  lcls_pkg::status_e    fast_st_q;
  logic                 dstart;
  logic [DW-1:0]        dquo;
  logic                 ddone;

  // operand selection for the current term
  logic signed [RB:0] da, db, dc, dd;
  logic signed [31:0] yi;
  always_comb begin
    logic signed [RB:0] xx, x0, x1, x2;
    xx = {x_q[RB-1], x_q};
    x0 = {pr_q[0][RB-1], pr_q[0]};
    x1 = {pr_q[1][RB-1], pr_q[1]};
    x2 = {pr_q[2][RB-1], pr_q[2]};
    case (term_q)
      2'd0: begin da = xx - x1; db = xx - x2; dc = x0 - x1; dd = x0 - x2; yi = pf_q[0]; end
      2'd1: begin da = xx - x0; db = xx - x2; dc = x1 - x0; dd = x1 - x2; yi = pf_q[1]; end
      default: begin da = xx - x0; db = xx - x1; dc = x2 - x0; dd = x2 - x1; yi = pf_q[2]; end
    endcase
  end

  function automatic logic [RB:0] mag(input logic signed [RB:0] v);
    mag = v[RB] ? (RB+1)'(0) - v : v;
  endfunction

  logic [31:0]  ymag;
  assign ymag = yi[31] ? 32'd0 - yi : yi;

  // saturation of the Lagrange sum
  logic signed [31:0] cal_sat;
  always_comb begin
    if (sum_q > DW'(signed'(32'sh7fffffff)))        cal_sat = 32'sh7fffffff;
    else if (sum_q < DW'(signed'(32'sh80000000)))   cal_sat = 32'sh80000000;
    else                                            cal_sat = sum_q[31:0];
  end

  logic signed [RB:0] mdiff;
  logic [31:0]        cmag;
  assign mdiff = {x_q[RB-1], x_q} - {zoff_q[RB-1], zoff_q};
  assign cmag  = cal_sat[31] ? 32'd0 - cal_sat : cal_sat;

  logic coincide;
  assign coincide = (pr_q[0] == pr_q[1]) || (pr_q[0] == pr_q[2]) || (pr_q[1] == pr_q[2]);

  // term numerator |a*b|*|y| from two partial products on the low 32 bits and the high bits of a*b
  logic [DW-1:0] dnum, dden;
  logic [63:0]   lo_prod, hi_prod;
  logic [DW-1:0] tnum;
  assign lo_prod = pab_q[31:0] * ymag;
  assign hi_prod = pab_q[2*RB+1:32] * ymag;
  assign tnum    = (DW'(hi_prod) << 32) + DW'(lo_prod);

  always_comb begin
    state_d = state_q;
    dstart  = 1'b0;
    dnum    = tnum;
    dden    = DW'(pcd_q);
    case (state_q)
      StIdle: if (in_valid_i) state_d = (in_item_i.command || coincide) ? StOut : StMulA;
      StMulA: state_d = StMulB;
      StMulB: state_d = StMulC;
      StMulC: begin dstart = 1'b1; state_d = StDiv; end
      StDiv:  if (ddone) state_d = (term_q == 2'd3) ? StOut : StMass;
      StMass: begin
        if (term_q == 2'd2) begin
          dden = DW'(cmag);
          dnum = DW'(mag(mdiff)) << (2 * FRAC_BITS);
          if (cal_sat != 0) dstart = 1'b1;
          state_d = (cal_sat != 0) ? StDiv : StOut;
        end else state_d = StMulA;
      end
      // wait here while an older result still sits in the output register
      StOut:  if (!ovalid_q || out_ready_i) state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  lcls_div #(.W(DW)) u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(dstart),
    .num_i  (dnum),
    .den_i  (dden),
    .done_o (ddone),
    .quo_o  (dquo)
  );

  logic [DW-1:0] sq;
  assign sq = neg_q ? DW'(0) - dquo : dquo;
  logic        mneg;
  assign mneg = mdiff[RB] ^ cal_sat[31];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= StIdle;
      ovalid_q  <= 1'b0;
      zoff_q    <= '0;
      term_q    <= '0;
      res_q     <= '0;
      fast_q    <= 1'b0;
      fast_st_q <= lcls_pkg::StatusOk;
    end else begin
      state_q <= state_d;
      if (state_q == StOut && (!ovalid_q || out_ready_i)) ovalid_q <= 1'b1;
      else if (out_ready_i) ovalid_q <= 1'b0;
      case (state_q)
        StIdle: if (in_valid_i) begin
          term_q <= '0;
          fast_q <= in_item_i.command || coincide;
          if (in_item_i.command) begin
            zoff_q    <= in_item_i.raw_reading[RB-1:0];
            fast_st_q <= lcls_pkg::StatusOk;
          end else begin
            fast_st_q <= lcls_pkg::StatusCoincide;
          end
        end
        StMass: if (term_q != 2'd2) term_q <= term_q + 2'd1;
                else if (cal_sat != 0) term_q <= 2'd3;
        StOut: if (!ovalid_q || out_ready_i) begin
          if (fast_q) begin
            res_q <= '{mass: '0, cal_factor: '0, status: fast_st_q};
          end else if (term_q != 2'd3) begin
            res_q <= '{mass: '0, cal_factor: '0, status: lcls_pkg::StatusZero};
          end else if (dquo <= (mneg ? DW'(33'h80000000) : DW'(32'h7fffffff))) begin
            res_q <= '{mass: mneg ? 32'd0 - dquo[31:0] : dquo[31:0],
                       cal_factor: cal_sat, status: lcls_pkg::StatusOk};
          end else begin
            res_q <= '{mass: mneg ? 32'sh80000000 : 32'sh7fffffff,
                       cal_factor: cal_sat, status: lcls_pkg::StatusSat};
          end
        end
        default: ;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    case (state_q)
      StIdle: begin
        x_q   <= in_item_i.raw_reading[RB-1:0];
        sum_q <= '0;
      end
      StMulA: begin
        ma_q  <= mag(da); mb_q <= mag(db); mc_q <= mag(dc); md_q <= mag(dd);
        neg_q <= (da[RB] ^ db[RB]) ^ (yi[31] ^ (dc[RB] ^ dd[RB]));
      end
      StMulB: begin
        pab_q <= ma_q * mb_q;
        pcd_q <= mc_q * md_q;
      end
      StDiv:  if (ddone && term_q != 2'd3) sum_q <= sum_q + sq;
      default: ;
    endcase
  end

  assign in_ready_o  = (state_q == StIdle);
  assign out_valid_o = ovalid_q;
  assign out_item_o  = res_q;

  // ---------------- checks ----------------
  a_busy_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != StIdle) |-> !in_ready_o) else $error("ready while busy");
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> $stable(out_item_o)) else $error("result moved");
  a_start_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dstart |-> (state_q == StMulC || state_q == StMass)) else $error("bad start");
  a_zero_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_item_o.status == lcls_pkg::StatusZero) |-> out_item_o.mass == 0)
    else $error("mass on zero factor");

endmodule

>>> test/load_cell_lagrange_scale_top_test.sv
`timescale 1ns / 1ps
module load_cell_lagrange_scale_top_test;

  // Drain wait, long enough for a measure item through the shared divider.
  localparam int unsigned DrainCycles = 700;
  // Longest quiet stretch: one measure item plus the long receiver hold-off.
  localparam int unsigned HoldCycles  = 3000;
  localparam int unsigned QuietLimit  = 20000;
  localparam int unsigned PhaseItems  = 345;
  localparam int unsigned AddrW       = lcls_pkg::AddrBits;

  typedef logic signed [127:0] wide_t;

  typedef enum logic { RowItem, RowCfg } row_kind_e;

  // One row of the directed table: either a register write or an item.
  // Where typed is set, exp_item is the known answer; otherwise the
  // predictor supplies it.
  typedef struct {
    row_kind_e           kind;
    lcls_pkg::reg_idx_e  idx;
    logic [31:0]         value;
    logic                command;
    logic signed [23:0]  reading;
    bit                  typed;
    lcls_pkg::out_item_t exp_item;
  } row_t;

  logic                clk_i = 1'b0;
  logic                rst_ni;
  logic                in_valid_i;
  logic                in_ready_o;
  lcls_pkg::in_item_t  in_item_i;
  logic                out_valid_o;
  logic                out_ready_i;
  lcls_pkg::out_item_t out_item_o;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [AddrW-1:0]    paddr;
  logic [31:0]         pwdata;
  logic [31:0]         prdata;
  logic                pready;

  load_cell_lagrange_scale_top i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_item_o  (out_item_o),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Predictor copy of the calibration points, factors and zero offset.
  logic signed [23:0] point_reading [3];
  logic signed [31:0] point_factor [3];
  logic signed [23:0] tare_offset;

  lcls_pkg::out_item_t weight_q [$];   // results still owed by the block
  bit          failed;
  int unsigned sender_idle_pct;
  int unsigned receiver_idle_pct;
  bit          hold_go;
  int unsigned quiet_cycles = 0;

  // Typed expectation travels with the item being offered.
  bit                  cur_typed;
  lcls_pkg::out_item_t cur_exp;

  // Lagrange interpolation of counts per gram, then mass = diff / c(x).
  function automatic lcls_pkg::out_item_t predict_weight(logic command,
                                                         logic signed [23:0] x);
    wide_t               xw, x0, x1, x2, sum, quot, calw;
    lcls_pkg::out_item_t res;
    res = '0;
    if (command) begin
      tare_offset = x;
      return res;
    end
    if (point_reading[0] == point_reading[1] || point_reading[0] == point_reading[2] ||
        point_reading[1] == point_reading[2]) begin
      res.status = lcls_pkg::StatusCoincide;
      return res;
    end
    xw = x;
    x0 = point_reading[0];
    x1 = point_reading[1];
    x2 = point_reading[2];
    // each term truncates toward zero on its own, as signed division does
    sum = ((xw - x1) * (xw - x2) * wide_t'(point_factor[0])) / ((x0 - x1) * (x0 - x2));
    sum = sum + ((xw - x0) * (xw - x2) * wide_t'(point_factor[1])) / ((x1 - x0) * (x1 - x2));
    sum = sum + ((xw - x0) * (xw - x1) * wide_t'(point_factor[2])) / ((x2 - x0) * (x2 - x1));
    if (sum > wide_t'(32'sh7fff_ffff)) calw = wide_t'(32'sh7fff_ffff);
    else if (sum < -wide_t'(64'sh8000_0000)) calw = -wide_t'(64'sh8000_0000);
    else calw = sum;
    res.cal_factor = calw[31:0];
    if (calw == 0) begin
      res.cal_factor = '0;
      res.status     = lcls_pkg::StatusZero;
      return res;
    end
    quot = ((xw - wide_t'(tare_offset)) <<< (2 * lcls_pkg::FracBits)) / calw;
    if (quot > wide_t'(32'sh7fff_ffff)) begin
      res.mass   = 32'sh7fff_ffff;
      res.status = lcls_pkg::StatusSat;
    end else if (quot < -wide_t'(64'sh8000_0000)) begin
      res.mass   = 32'sh8000_0000;
      res.status = lcls_pkg::StatusSat;
    end else begin
      res.mass   = quot[31:0];
    end
    return res;
  endfunction

  // Input acceptance: predict and queue; output acceptance: check.
  always @(posedge clk_i) begin
    lcls_pkg::out_item_t predicted;
    lcls_pkg::out_item_t want;
    if (in_valid_i && in_ready_o) begin
      predicted = predict_weight(in_item_i.command, in_item_i.raw_reading);
      weight_q.push_back(cur_typed ? cur_exp : predicted);
    end
    if (out_valid_o && out_ready_i) begin
      if (weight_q.size() == 0) begin
        $error("result with nothing expected: mass %0d", out_item_o.mass);
        failed = 1'b1;
      end else begin
        want = weight_q.pop_front();
        if (out_item_o.mass !== want.mass) begin
          $error("mass expected %0d actual %0d", want.mass, out_item_o.mass);
          failed = 1'b1;
        end
        if (out_item_o.cal_factor !== want.cal_factor) begin
          $error("cal_factor expected %0d actual %0d", want.cal_factor,
                 out_item_o.cal_factor);
          failed = 1'b1;
        end
        if (out_item_o.status !== want.status) begin
          $error("status expected %0d actual %0d", want.status, out_item_o.status);
          failed = 1'b1;
        end
      end
    end
  end

  // Watchdog: any handshake or config write resets the quiet count.
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) || (psel && penable))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QuietLimit) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // Receiver: random stalls, or a long hold-off on request.
  initial begin
    out_ready_i <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_go) begin
        hold_go = 1'b0;
        repeat (HoldCycles) begin
          out_ready_i <= 1'b0;
          @(posedge clk_i);
        end
      end
      out_ready_i <= ($urandom_range(99) >= receiver_idle_pct);
    end
  end

  task automatic write_reg(lcls_pkg::reg_idx_e idx, logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= AddrW'(4 * idx);
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);   // pready is tied high: written at this edge
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);   // bus idles between transfers
    if (idx <= lcls_pkg::RegP2Read) point_reading[idx] = value[23:0];
    else point_factor[idx - lcls_pkg::RegP0Fact] = value;
  endtask

  // Config only once the block holds nothing.
  task automatic wait_drained();
    while (weight_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic send_item(logic command, logic signed [23:0] reading, bit typed,
                           lcls_pkg::out_item_t exp_item);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i            <= 1'b1;
    in_item_i.command     <= command;
    in_item_i.raw_reading <= reading;
    cur_typed             <= typed;
    cur_exp               <= exp_item;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  function automatic logic [31:0] rand_factor();
    case ($urandom_range(3))
      0: rand_factor = $urandom();                              // anything
      1: rand_factor = $urandom_range(32'h03e8_0000, 32'h0001_0000);
      2: rand_factor = -$urandom_range(32'h03e8_0000, 32'h0001_0000);
      default: rand_factor = $urandom_range(32'h0000_ffff, 1);  // tiny: saturates mass
    endcase
  endfunction

  function automatic logic signed [23:0] rand_reading();
    case ($urandom_range(3))
      0: rand_reading = $urandom_range(200000) - 100000;
      1: rand_reading = point_reading[$urandom_range(2)] + $urandom_range(8) - 4;
      default: rand_reading = $urandom();
    endcase
  endfunction

  row_t                dir_rows [$];
  lcls_pkg::out_item_t none_item;
  lcls_pkg::out_item_t coincide_item;
  lcls_pkg::out_item_t zero_item;

  initial begin
    none_item         = '0;
    coincide_item     = '0;
    coincide_item.status = lcls_pkg::StatusCoincide;
    zero_item         = '0;
    zero_item.status  = lcls_pkg::StatusZero;
    failed            = 1'b0;
    hold_go           = 1'b0;
    sender_idle_pct   = 0;
    receiver_idle_pct = 0;
    tare_offset       = '0;
    for (int i = 0; i < 3; i++) begin
      point_reading[i] = '0;
      point_factor[i]  = '0;
    end
    rst_ni     <= 1'b0;
    in_valid_i <= 1'b0;
    in_item_i  <= '0;
    cur_typed  <= 1'b0;
    cur_exp    <= '0;
    psel       <= 1'b0;
    penable    <= 1'b0;
    pwrite     <= 1'b0;
    paddr      <= '0;
    pwdata     <= '0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed table. After reset all points sit at zero, so they coincide.
    dir_rows.push_back('{RowItem, lcls_pkg::RegP0Read, 0, 1'b0, 24'sd0, 1, coincide_item});
    dir_rows.push_back('{RowItem, lcls_pkg::RegP0Read, 0, 1'b0, 24'sh7fffff, 1, coincide_item});
    dir_rows.push_back('{RowItem, lcls_pkg::RegP0Read, 0, 1'b1, 24'sh800000, 1, none_item});
    dir_rows.push_back('{RowItem, lcls_pkg::RegP0Read, 0, 1'b0, 24'sh800000, 1, coincide_item});
    // distinct points, factors still zero
    dir_rows.push_back('{RowCfg, lcls_pkg::RegP0Read, -32'sd4000000, 1'b0, 0, 0, none_item});
    dir_rows.push_back('{RowCfg, lcls_pkg::RegP1Read, 32'd100, 1'b0, 0, 0, none_item});
    dir_rows.push_back('{RowCfg, lcls_pkg::RegP2Read, 32'd4000000, 1'b0, 0, 0, none_item});
    dir_rows.push_back('{RowItem, lcls_pkg::RegP0Read, 0, 1'b0, 24'sd12345, 1, zero_item});
    dir_rows.push_back('{RowItem, lcls_pkg::RegP0Read, 0, 1'b0, 24'sh7fffff, 1, zero_item});
    // 1.5, 2.0, 2.5 counts per gram
    dir_rows.push_back('{RowCfg, lcls_pkg::RegP0Fact, 32'h0001_8000, 1'b0, 0, 0, none_item});
    dir_rows.push_back('{RowCfg, lcls_pkg::RegP1Fact, 32'h0002_0000, 1'b0, 0, 0, none_item});
    dir_rows.push_back('{RowCfg, lcls_pkg::RegP2Fact, 32'h0002_8000, 1'b0, 0, 0, none_item});
    dir_rows.push_back('{RowItem, lcls_pkg::RegP0Read, 0, 1'b1, 24'sd0, 1, none_item});
    dir_rows.push_back('{RowItem, lcls_pkg::RegP0Read, 0, 1'b0, 24'sd100, 0, none_item});
    dir_rows.push_back('{RowItem, lcls_pkg::RegP0Read, 0, 1'b0, 24'sh800000, 0, none_item});
    dir_rows.push_back('{RowItem, lcls_pkg::RegP0Read, 0, 1'b0, 24'sh7fffff, 0, none_item});
    dir_rows.push_back('{RowItem, lcls_pkg::RegP0Read, 0, 1'b0, -24'sd4000000, 0, none_item});
    dir_rows.push_back('{RowItem, lcls_pkg::RegP0Read, 0, 1'b0, 24'sd4000000, 0, none_item});
    // tiny factors: mass runs out of range both ways
    dir_rows.push_back('{RowCfg, lcls_pkg::RegP0Fact, 32'h0000_0001, 1'b0, 0, 0, none_item});
    dir_rows.push_back('{RowCfg, lcls_pkg::RegP1Fact, 32'h0000_0001, 1'b0, 0, 0, none_item});
    dir_rows.push_back('{RowCfg, lcls_pkg::RegP2Fact, 32'h0000_0001, 1'b0, 0, 0, none_item});
    dir_rows.push_back('{RowItem, lcls_pkg::RegP0Read, 0, 1'b0, 24'sh7fffff, 0, none_item});
    dir_rows.push_back('{RowItem, lcls_pkg::RegP0Read, 0, 1'b0, 24'sh800000, 0, none_item});
    // extreme factors: interpolated factor clamps
    dir_rows.push_back('{RowCfg, lcls_pkg::RegP0Fact, 32'h7fff_ffff, 1'b0, 0, 0, none_item});
    dir_rows.push_back('{RowCfg, lcls_pkg::RegP1Fact, 32'h8000_0000, 1'b0, 0, 0, none_item});
    dir_rows.push_back('{RowCfg, lcls_pkg::RegP2Fact, 32'h7fff_ffff, 1'b0, 0, 0, none_item});
    dir_rows.push_back('{RowItem, lcls_pkg::RegP0Read, 0, 1'b0, 24'sh7fffff, 0, none_item});
    dir_rows.push_back('{RowItem, lcls_pkg::RegP0Read, 0, 1'b0, 24'sh800000, 0, none_item});
    dir_rows.push_back('{RowItem, lcls_pkg::RegP0Read, 0, 1'b0, -24'sd1, 0, none_item});
    // two configured points meet again
    dir_rows.push_back('{RowCfg, lcls_pkg::RegP2Read, 32'd100, 1'b0, 0, 0, none_item});
    dir_rows.push_back('{RowItem, lcls_pkg::RegP0Read, 0, 1'b0, 24'sd55, 1, coincide_item});
    dir_rows.push_back('{RowItem, lcls_pkg::RegP0Read, 0, 1'b1, 24'sh7fffff, 1, none_item});

    foreach (dir_rows[r]) begin
      if (dir_rows[r].kind == RowCfg) begin
        in_valid_i <= 1'b0;
        wait_drained();
        write_reg(dir_rows[r].idx, dir_rows[r].value);
      end else begin
        send_item(dir_rows[r].command, dir_rows[r].reading, dir_rows[r].typed,
                  dir_rows[r].exp_item);
      end
    end

    // Random phases: new calibration each time, idling shifts as noted.
    for (int phase = 0; phase < 3; phase++) begin
      in_valid_i <= 1'b0;
      wait_drained();
      sender_idle_pct   = (phase == 0) ? 31 : (phase == 1) ? 66 : 0;
      receiver_idle_pct = (phase == 0) ? 66 : (phase == 1) ? 31 : 0;
      if (phase == 2) begin
        // extremes of the point readings and factors
        write_reg(lcls_pkg::RegP0Read, 32'hff80_0000);
        write_reg(lcls_pkg::RegP1Read, 32'd0);
        write_reg(lcls_pkg::RegP2Read, 32'h007f_ffff);
        write_reg(lcls_pkg::RegP0Fact, 32'h7fff_ffff);
        write_reg(lcls_pkg::RegP1Fact, 32'h8000_0000);
        write_reg(lcls_pkg::RegP2Fact, 32'h0001_0000);
      end else begin
        for (int i = 0; i < 3; i++)
          write_reg(lcls_pkg::reg_idx_e'(lcls_pkg::RegP0Read + i),
                    32'($signed(24'($urandom()))));
        for (int i = 0; i < 3; i++)
          write_reg(lcls_pkg::reg_idx_e'(lcls_pkg::RegP0Fact + i), rand_factor());
      end
      for (int n = 0; n < PhaseItems; n++) begin
        if (phase == 2 && n == 20) hold_go = 1'b1;  // stall the output, keep offering
        send_item($urandom_range(9) == 0, rand_reading(), 1'b0, none_item);
      end
    end
    in_valid_i <= 1'b0;

    while (weight_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (!failed) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
